[sv/cdh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdh_pkg: shared types and constants of the canonical distance heuristic
// Beat layouts of both channels, operation codes, configuration register
// indexes and register reset values.
// ----------------------------------------------------------------------------
package cdh_pkg;

	// fixed field widths of the channel beats
	localparam int NODE_W    = 12;
	localparam int CENTER_W  = 6;
	localparam int DIST_W    = 20;
	localparam int COUNT_W   = 13;
	localparam int CIU_W     = 2;
	localparam int CFG_W     = 13;

	// register reset values
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 13'd4096;
	localparam logic [CIU_W-1:0]   CIU_RST        = 2'd2;

	// operation codes
	typedef enum logic [1:0] {
		MODE_OFFER  = 2'd0,
		MODE_LENGTH = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_NODE_COUNT     = 1'b0,
		REG_CLOSEST_IN_USE = 1'b1
	} cfg_reg_t;

	// input beat
	typedef struct packed {
		mode_t               mode;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [CENTER_W-1:0] center_a;
		logic [CENTER_W-1:0] center_b;
		logic [DIST_W-1:0]   distance;
		logic [DIST_W-1:0]   base_estimate;
	} item_t;

	// result beat
	typedef struct packed {
		logic [DIST_W-1:0] estimate;
		logic              nodes_valid;
	} result_t;

endpackage
`default_nettype wire

[sv/canonical_distance_heuristic_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_distance_heuristic_core: k-closest-center search heuristic
// Keeps a sorted closest-center row per node and a center pair length table,
// serves offers, length writes and heuristic queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps the node row memory, one row a cycle, over all
// NODES rows (4096 by default) and takes no beat until the sweep is done;
// configuration writes are taken throughout. A length write is a single table
// write, an offer a row read, then a write back, and a query walks k*k center
// pairs, where k is the number of slots in use: both node rows come out of the
// row memory in one read, then the length table's single read port serves
// one center pair per cycle, followed by a two-stage evaluate and maximum.
// A finished result sits in an output register, so the next beat is taken
// while it waits; a second query stalls only at its end if the first result
// has still not been taken.
// ----------------------------------------------------------------------------
module canonical_distance_heuristic_core #(
	parameter int NODES     = 4096,
	parameter int CLOSEST   = 2,
	parameter int CENTERS   = 64,
	parameter int DIST_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  cdh_pkg::cfg_reg_t         cfg_index,
	input  logic [cdh_pkg::CFG_W-1:0] cfg_data,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  cdh_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output cdh_pkg::result_t          result
);

	import cdh_pkg::*;

	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(CENTERS);
	localparam int XW = (CLOSEST > 1) ? $clog2(CLOSEST) : 1;
	localparam int KW = $clog2(CLOSEST + 1);
	localparam int SW = DIST_BITS + CW;
	localparam int RW = CLOSEST * SW;
	localparam int LW = 2 * CW;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_PAIR,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [COUNT_W-1:0] node_count_q;
	logic [CIU_W-1:0]   ciu_q;
	logic [KW-1:0]      k_eff;
	logic [XW-1:0]      k_last;

	// accepted beat
	logic                 accept;
	logic [DIST_BITS-1:0] dist_in;
	logic                 centers_ok;
	mode_t                mode_q;
	logic                 nodes_ok_q;
	logic                 offer_ok_q;
	logic [NW-1:0]        addr_a_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [CW-1:0]        ctr_q;
	logic [DIST_BITS-1:0] base_q;

	// row memory
	logic [NW-1:0]                clr_q;
	logic                         slot_we;
	logic [NW-1:0]                slot_waddr;
	logic [CLOSEST-1:0][SW-1:0]   slot_wdata;
	logic [CLOSEST-1:0][SW-1:0]   clear_row;
	logic [CLOSEST-1:0][SW-1:0]   row_a;
	logic [CLOSEST-1:0][SW-1:0]   row_b;
	logic [CLOSEST-1:0][SW-1:0]   new_row;

	// length table
	logic             len_we;
	logic [LW-1:0]    len_waddr;
	logic [LW-1:0]    len_raddr;
	logic [DIST_BITS-1:0] len_rdata;
	logic [CW-1:0]    ca_w;
	logic [CW-1:0]    cb_w;

	// pair walk and evaluate pipeline
	logic [XW-1:0]        x_q;
	logic [XW-1:0]        y_q;
	logic [DIST_BITS-1:0] d1;
	logic [DIST_BITS-1:0] d2;
	logic [CW-1:0]        c1;
	logic [CW-1:0]        c2;
	logic                 pv_s1;
	logic                 pv_s2;
	logic                 same_s1;
	logic [DIST_BITS:0]   dsum_s1;
	logic [DIST_BITS-1:0] ddiff_s1;
	logic [DIST_BITS-1:0] cand_s2;
	logic [DIST_BITS-1:0] best_q;
	logic [DIST_BITS-1:0] est_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			ciu_q        <= CIU_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT:     node_count_q <= cfg_data[COUNT_W-1:0];
				REG_CLOSEST_IN_USE: ciu_q        <= cfg_data[CIU_W-1:0];
				default: ;
			endcase
		end
	end

	// slots in use, clamped to 1..CLOSEST
	always_comb begin
		if (ciu_q == '0)
			k_eff = KW'(1);
		else if (32'(ciu_q) > CLOSEST)
			k_eff = KW'(CLOSEST);
		else
			k_eff = KW'(ciu_q);
		k_last = XW'(k_eff - KW'(1));
	end

	// input beat decode
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign dist_in    = DIST_BITS'(item.distance);
	assign centers_ok = (32'(item.center_a) < CENTERS) && (32'(item.center_b) < CENTERS);

	// accepted beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= item.mode;
			nodes_ok_q <= (COUNT_W'(item.node_a) < node_count_q) &&
				(COUNT_W'(item.node_b) < node_count_q) &&
				(32'(item.node_a) < NODES) && (32'(item.node_b) < NODES);
			offer_ok_q <= (32'(item.node_a) < NODES) && (32'(item.center_a) < CENTERS);
			addr_a_q   <= NW'(item.node_a);
			dist_q     <= dist_in;
			ctr_q      <= CW'(item.center_a);
			base_q     <= DIST_BITS'(item.base_estimate);
		end
	end

	// row memory write side: clearing sweep or offer write back
	always_comb begin
		for (int i = 0; i < CLOSEST; i++)
			clear_row[i] = {{DIST_BITS{1'b1}}, {CW{1'b0}}};
		if (state_q == ST_CLEAR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
			slot_wdata = clear_row;
		end else begin
			slot_we    = (state_q == ST_ROW) && (mode_q == MODE_OFFER) && offer_ok_q;
			slot_waddr = addr_a_q;
			slot_wdata = new_row;
		end
	end

	cdh_slot_ram #(
		.DEPTH (NODES),
		.AW    (NW),
		.WIDTH (RW)
	) u_slot_ram (
		.clk     (clk),
		.we      (slot_we),
		.waddr   (slot_waddr),
		.wdata   (slot_wdata),
		.re      (accept && (item.mode == MODE_OFFER || item.mode == MODE_QUERY)),
		.raddr_a (NW'(item.node_a)),
		.raddr_b (NW'(item.node_b)),
		.rdata_a (row_a),
		.rdata_b (row_b)
	);

	cdh_insert #(
		.CLOSEST   (CLOSEST),
		.DIST_BITS (DIST_BITS),
		.CW        (CW),
		.KW        (KW)
	) u_insert (
		.row_in   (row_a),
		.k_used   (k_eff),
		.dist_new (dist_q),
		.ctr_new  (ctr_q),
		.row_out  (new_row)
	);

	// length write goes to the {lower, higher} entry of the pair
	assign ca_w      = CW'(item.center_a);
	assign cb_w      = CW'(item.center_b);
	assign len_we    = accept && (item.mode == MODE_LENGTH) && centers_ok;
	assign len_waddr = (ca_w <= cb_w) ? {ca_w, cb_w} : {cb_w, ca_w};

	// current slot pair, unfilled slots read as distance 0, center 0
	always_comb begin
		if (row_a[x_q][SW-1 -: DIST_BITS] == {DIST_BITS{1'b1}}) begin
			d1 = '0;
			c1 = '0;
		end else begin
			d1 = row_a[x_q][SW-1 -: DIST_BITS];
			c1 = row_a[x_q][CW-1:0];
		end
		if (row_b[y_q][SW-1 -: DIST_BITS] == {DIST_BITS{1'b1}}) begin
			d2 = '0;
			c2 = '0;
		end else begin
			d2 = row_b[y_q][SW-1 -: DIST_BITS];
			c2 = row_b[y_q][CW-1:0];
		end
		len_raddr = (c1 <= c2) ? {c1, c2} : {c2, c1};
	end

	cdh_len_ram #(
		.AW    (LW),
		.WIDTH (DIST_BITS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (dist_in),
		.re    (state_q == ST_PAIR),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	// evaluate pipeline: offsets, then candidate, then running maximum
	always_ff @(posedge clk) begin
		same_s1  <= (c1 == c2);
		dsum_s1  <= (DIST_BITS+1)'(d1) + (DIST_BITS+1)'(d2);
		ddiff_s1 <= (d1 >= d2) ? d1 - d2 : d2 - d1;
		if (same_s1)
			cand_s2 <= ddiff_s1;
		else if ({1'b0, len_rdata} >= dsum_s1)
			cand_s2 <= DIST_BITS'({1'b0, len_rdata} - dsum_s1);
		else
			cand_s2 <= '0;
		if (state_q == ST_ROW)
			best_q <= '0;
		else if (pv_s2 && cand_s2 > best_q)
			best_q <= cand_s2;
	end

	assign est_full = (best_q > base_q) ? best_q : base_q;

	// sequencer with result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			x_q          <= '0;
			y_q          <= '0;
			pv_s1        <= 1'b0;
			pv_s2        <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			pv_s1 <= (state_q == ST_PAIR);
			pv_s2 <= pv_s1;
			if (result_valid && result_ready)
				result_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(NODES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && (item.mode == MODE_OFFER || item.mode == MODE_QUERY))
						state_q <= ST_ROW;
				end
				ST_ROW: begin
					x_q <= '0;
					y_q <= '0;
					if (mode_q == MODE_QUERY)
						state_q <= ST_PAIR;
					else
						state_q <= ST_IDLE;
				end
				ST_PAIR: begin
					if (y_q == k_last) begin
						y_q <= '0;
						if (x_q == k_last)
							state_q <= ST_DRAIN;
						else
							x_q <= x_q + XW'(1);
					end else begin
						y_q <= y_q + XW'(1);
					end
				end
				ST_DRAIN: begin
					if (!pv_s1)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!result_valid || result_ready) begin
						result_valid       <= 1'b1;
						result.nodes_valid <= nodes_ok_q;
						result.estimate    <= nodes_ok_q ? DIST_W'(est_full) : '0;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[sv/cdh_slot_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdh_slot_ram: per-node closest-center row storage
// One write port and two registered read ports, one row per node.
// ----------------------------------------------------------------------------
module cdh_slot_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int WIDTH = 52
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and dual registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

[sv/cdh_len_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdh_len_ram: center pair length table
// One entry per unordered center pair, addressed by {lower, higher} center.
// ----------------------------------------------------------------------------
module cdh_len_ram #(
	parameter int AW    = 12,
	parameter int WIDTH = 20
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [2**AW];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/cdh_insert.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdh_insert: sorted insert of an offered distance into one node row
// The new entry goes ahead of the first in-use slot holding a strictly larger
// distance; later in-use slots move down one place and the last drops out.
// ----------------------------------------------------------------------------
module cdh_insert #(
	parameter int CLOSEST   = 2,
	parameter int DIST_BITS = 20,
	parameter int CW        = 6,
	parameter int KW        = 2
) (
	input  logic [CLOSEST-1:0][DIST_BITS+CW-1:0] row_in,
	input  logic [KW-1:0]                        k_used,
	input  logic [DIST_BITS-1:0]                 dist_new,
	input  logic [CW-1:0]                        ctr_new,
	output logic [CLOSEST-1:0][DIST_BITS+CW-1:0] row_out
);

	localparam int SW = DIST_BITS + CW;

	logic [CLOSEST-1:0] lt;
	logic               found;

	// per-slot compare against in-use entries
	always_comb begin
		for (int i = 0; i < CLOSEST; i++)
			lt[i] = (i < int'(k_used)) && (dist_new < row_in[i][SW-1 -: DIST_BITS]);
	end

	// shift and insert
	always_comb begin
		found = 1'b0;
		for (int w = 0; w < CLOSEST; w++) begin
			if (w >= int'(k_used))
				row_out[w] = row_in[w];
			else if (found)
				row_out[w] = row_in[(w > 0) ? w - 1 : 0];
			else if (lt[w])
				row_out[w] = {dist_new, ctr_new};
			else
				row_out[w] = row_in[w];
			found = found | lt[w];
		end
	end

endmodule
`default_nettype wire
